/* sv/bcnp_pkg.sv */
// bcnp_pkg: shared widths, payload types, register codes and the distance
// helper for the box corner nearest point block. No dependencies.
package bcnp_pkg;

  localparam int COORD_W   = 20;
  localparam int ID_W      = 16;
  localparam int DIST_W    = 42;
  localparam int CORNERS   = 8;
  localparam int AXES      = 3;
  localparam int CIDX_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int MAG_W     = COORD_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [ID_W-1:0]           vid_t;
  typedef logic [CIDX_W-1:0]         cidx_t;

  localparam dist_t DIST_MAX     = '1;
  localparam dist_t CUTOFF_RESET = 42'd65536000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X  = 3'd0,
    CFG_BOX_MIN_Y  = 3'd1,
    CFG_BOX_MIN_Z  = 3'd2,
    CFG_BOX_MAX_X  = 3'd3,
    CFG_BOX_MAX_Y  = 3'd4,
    CFG_BOX_MAX_Z  = 3'd5,
    CFG_CUTOFF_SQ  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    vid_t   vertex_id;
    coord_t x_coord;
    coord_t y_coord;
    coord_t z_coord;
    logic   final_vertex;
  } in_item_t;

  typedef struct packed {
    cidx_t corner_index;
    vid_t  nearest_id;
    logic  found;
    logic  last_result;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DIST_W-1:0]    value;
  } cfg_wr_t;

  // Box bounds per axis (0 = x, 1 = y, 2 = z) and the distance cutoff.
  typedef struct packed {
    coord_t [AXES-1:0] lo;
    coord_t [AXES-1:0] hi;
    dist_t             cutoff;
  } box_cfg_t;

  // Per-axis squared distances to the low and high bound.
  typedef struct packed {
    vid_t             vertex_id;
    logic             final_vertex;
    dist_t [AXES-1:0] sq_lo;
    dist_t [AXES-1:0] sq_hi;
  } sq_item_t;

  // Snapshot handed to the result buffer at the end of a set.
  typedef struct packed {
    logic                  load;
    logic [CORNERS-1:0]    found;
    vid_t [CORNERS-1:0]    ids;
  } snap_t;

  // Squared difference of two coordinates.
  function automatic dist_t sq_diff(input coord_t p, input coord_t b);
    logic signed [MAG_W-1:0] d;
    logic [MAG_W-1:0]        m;
    logic [2*MAG_W-1:0]      p2;
    d  = $signed({p[COORD_W-1], p}) - $signed({b[COORD_W-1], b});
    m  = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
    p2 = m * m;
    return DIST_W'(p2);
  endfunction

endpackage

/* sv/bcnp_in_if.sv */
// bcnp_in_if: vertex input channel (valid, ready, payload).
// Depends on bcnp_pkg.
interface bcnp_in_if;
  import bcnp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/bcnp_out_if.sv */
// bcnp_out_if: result channel (valid, ready, payload).
// Depends on bcnp_pkg.
interface bcnp_out_if;
  import bcnp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/bcnp_cfg_if.sv */
// bcnp_cfg_if: configuration write channel (valid, ready, index and data).
// Depends on bcnp_pkg.
interface bcnp_cfg_if;
  import bcnp_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/bcnp_cfg_regs.sv */
// bcnp_cfg_regs: box bound and cutoff registers written over the cfg channel.
// Depends on bcnp_pkg and bcnp_cfg_if.
module bcnp_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  bcnp_cfg_if.sink           cfg_ch,
  output bcnp_pkg::box_cfg_t box
);
  import bcnp_pkg::*;

  box_cfg_t box_r;

  assign cfg_ch.ready = 1'b1;
  assign box          = box_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.lo     <= '0;
      box_r.hi     <= '0;
      box_r.cutoff <= CUTOFF_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        CFG_BOX_MIN_X: box_r.lo[0]  <= coord_t'(cfg_ch.data.value[COORD_W-1:0]);
        CFG_BOX_MIN_Y: box_r.lo[1]  <= coord_t'(cfg_ch.data.value[COORD_W-1:0]);
        CFG_BOX_MIN_Z: box_r.lo[2]  <= coord_t'(cfg_ch.data.value[COORD_W-1:0]);
        CFG_BOX_MAX_X: box_r.hi[0]  <= coord_t'(cfg_ch.data.value[COORD_W-1:0]);
        CFG_BOX_MAX_Y: box_r.hi[1]  <= coord_t'(cfg_ch.data.value[COORD_W-1:0]);
        CFG_BOX_MAX_Z: box_r.hi[2]  <= coord_t'(cfg_ch.data.value[COORD_W-1:0]);
        CFG_CUTOFF_SQ: box_r.cutoff <= cfg_ch.data.value;
        default: ;
      endcase
    end
  end

endmodule

/* sv/bcnp_sq_stage.sv */
// bcnp_sq_stage: input register, then six per-axis squared differences
// (vertex to low and high bound) into a register. Depends on bcnp_pkg.
module bcnp_sq_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  bcnp_pkg::in_item_t in_item,
  input  bcnp_pkg::box_cfg_t box,
  output logic               sq_valid,
  output bcnp_pkg::sq_item_t sq_item
);
  import bcnp_pkg::*;

  logic     v1_r;
  in_item_t item1_r;
  logic     v2_r;
  sq_item_t sq2_r;
  sq_item_t sq2_nxt;
  coord_t [AXES-1:0] pos;

  assign pos[0] = item1_r.x_coord;
  assign pos[1] = item1_r.y_coord;
  assign pos[2] = item1_r.z_coord;

  always_comb begin
    sq2_nxt.vertex_id    = item1_r.vertex_id;
    sq2_nxt.final_vertex = item1_r.final_vertex;
    for (int a = 0; a < AXES; a++) begin
      sq2_nxt.sq_lo[a] = sq_diff(pos[a], box.lo[a]);
      sq2_nxt.sq_hi[a] = sq_diff(pos[a], box.hi[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item1_r <= in_item;
      sq2_r   <= sq2_nxt;
    end
  end

  assign sq_valid = v2_r;
  assign sq_item  = sq2_r;

endmodule

/* sv/bcnp_best_track.sv */
// bcnp_best_track: per-corner distance sum, compare and best update; builds
// the end-of-set snapshot and clears the corners. Depends on bcnp_pkg.
module bcnp_best_track (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               sq_valid,
  input  bcnp_pkg::sq_item_t sq_item,
  input  bcnp_pkg::dist_t    cutoff,
  output bcnp_pkg::snap_t    snap
);
  import bcnp_pkg::*;

  dist_t [CORNERS-1:0] best_d_r;
  vid_t  [CORNERS-1:0] best_id_r;
  logic  [CORNERS-1:0] found_r;

  dist_t [CORNERS-1:0] corner_d;
  logic  [CORNERS-1:0] upd;
  logic  [CORNERS-1:0] found_new;
  vid_t  [CORNERS-1:0] id_new;
  logic                take;

  assign take = sq_valid && adv;

  always_comb begin
    logic [DIST_W+1:0] s;
    cidx_t             cb;
    for (int c = 0; c < CORNERS; c++) begin
      cb = cidx_t'(c);
      s  = {2'b00, (cb[0] ? sq_item.sq_hi[0] : sq_item.sq_lo[0])}
         + {2'b00, (cb[1] ? sq_item.sq_hi[1] : sq_item.sq_lo[1])}
         + {2'b00, (cb[2] ? sq_item.sq_hi[2] : sq_item.sq_lo[2])};
      corner_d[c]  = (s > {2'b00, DIST_MAX}) ? DIST_MAX : s[DIST_W-1:0];
      // strict compares: earliest vertex keeps a tie
      upd[c]       = take && (corner_d[c] < cutoff) &&
                     (!found_r[c] || corner_d[c] < best_d_r[c]);
      found_new[c] = found_r[c] | upd[c];
      id_new[c]    = upd[c] ? sq_item.vertex_id : best_id_r[c];
    end
  end

  always_comb begin
    snap.load  = take && sq_item.final_vertex;
    snap.found = found_new;
    for (int c = 0; c < CORNERS; c++) begin
      snap.ids[c] = found_new[c] ? id_new[c] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
    end else if (take) begin
      found_r <= sq_item.final_vertex ? '0 : found_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < CORNERS; c++) begin
      if (upd[c]) begin
        best_d_r[c]  <= corner_d[c];
        best_id_r[c] <= sq_item.vertex_id;
      end
    end
  end

endmodule

/* sv/bcnp_result_buf.sv */
// bcnp_result_buf: holds the eight corner results of a finished set and
// sends them one per transfer. Depends on bcnp_pkg and bcnp_out_if.
module bcnp_result_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  bcnp_pkg::snap_t snap,
  output logic            buf_free,
  bcnp_out_if.source      out_ch
);
  import bcnp_pkg::*;

  logic               out_v_r;
  cidx_t              idx_r;
  logic [CORNERS-1:0] found_r;
  vid_t [CORNERS-1:0] ids_r;
  logic               xfer;
  logic               last;

  localparam cidx_t LAST_IDX = cidx_t'(CORNERS - 1);

  assign last     = (idx_r == LAST_IDX);
  assign xfer     = out_v_r && out_ch.ready;
  assign buf_free = !out_v_r || (xfer && last);

  assign out_ch.valid             = out_v_r;
  assign out_ch.data.corner_index = idx_r;
  assign out_ch.data.nearest_id   = ids_r[idx_r];
  assign out_ch.data.found        = found_r[idx_r];
  assign out_ch.data.last_result  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      idx_r   <= '0;
    end else if (snap.load) begin
      out_v_r <= 1'b1;
      idx_r   <= '0;
    end else if (xfer) begin
      out_v_r <= !last;
      idx_r   <= idx_r + cidx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (snap.load) begin
      found_r <= snap.found;
      ids_r   <= snap.ids;
    end
  end

endmodule

/* sv/box_corner_nearest_point_top.sv */
// box_corner_nearest_point_top: nearest streamed vertex to each box corner.
// Depends on bcnp_pkg, the channel interfaces and the bcnp_* submodules.
//
// Usage:
//  - in_ch carries one vertex per transfer: id, signed Q11.8 x/y/z and a
//    final_vertex flag that closes the current set.
//  - cfg_ch writes the six box bounds and the squared cutoff (Q.16); it is
//    always ready and is meant to be written while the block is idle.
//  - out_ch sends eight results per set, corners 0..7 in order (bit0 x max,
//    bit1 y max, bit2 z max), last_result set on corner 7. A corner with no
//    vertex strictly inside the cutoff reports found = 0 and id 0.
// Timing:
//  - One vertex per cycle while the input is not held (see below). Pipeline:
//    input register, squarer register (six 21x21 squares), then
//    sum/compare/update of the eight corner bests. Corner 0 of a set becomes
//    valid once the final vertex has passed these stages and loaded the
//    result buffer; the eight results then go out one per transfer.
//  - The next set streams in while results drain. A final vertex that
//    reaches the update stage while the previous eight results are still
//    draining holds the whole input pipeline (in_ch.ready low).
// Reset (rst_n low, synchronous): bounds 0, cutoff 1000^2, no corners found,
//  no results pending. A receiver stall just holds the current result.
module box_corner_nearest_point_top (
  input logic        clk,
  input logic        rst_n,
  bcnp_in_if.sink    in_ch,
  bcnp_out_if.source out_ch,
  bcnp_cfg_if.sink   cfg_ch
);
  import bcnp_pkg::*;

  box_cfg_t box;
  logic     sq_valid;
  sq_item_t sq_item;
  snap_t    snap;
  logic     buf_free;
  logic     adv;

  // Pipeline advances unless a set end would overwrite undrained results.
  assign adv         = !(sq_valid && sq_item.final_vertex) || buf_free;
  assign in_ch.ready = adv;

  bcnp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .box    (box)
  );

  bcnp_sq_stage u_sq (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .in_item  (in_ch.data),
    .box      (box),
    .sq_valid (sq_valid),
    .sq_item  (sq_item)
  );

  bcnp_best_track u_best (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .sq_valid (sq_valid),
    .sq_item  (sq_item),
    .cutoff   (box.cutoff),
    .snap     (snap)
  );

  bcnp_result_buf u_res (
    .clk      (clk),
    .rst_n    (rst_n),
    .snap     (snap),
    .buf_free (buf_free),
    .out_ch   (out_ch)
  );

endmodule

/* sv/bcnp_checker.sv */
// bcnp_checker: port-level checks on the result channel, bound to the top.
// No package dependency.
module bcnp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  corner_index,
  input logic [15:0] nearest_id,
  input logic        found,
  input logic        last_result
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(corner_index))
    else $error("result dropped or changed while stalled");

  // within a set, corners follow back to back in order
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && corner_index != 3'd7 |=>
      out_valid && corner_index == 3'($past(corner_index) + 3'd1))
    else $error("corner sequence broken");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_result == (corner_index == 3'd7)))
    else $error("last_result not on corner 7");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> nearest_id == 16'd0)
    else $error("nonzero id for empty corner");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind box_corner_nearest_point_top bcnp_checker u_bcnp_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .corner_index (out_ch.data.corner_index),
  .nearest_id   (out_ch.data.nearest_id),
  .found        (out_ch.data.found),
  .last_result  (out_ch.data.last_result)
);

/* sim/bcnp_corner_checker.sv */
// bcnp_corner_checker: predicts the eight per-corner nearest vertices from the
// observed vertex and config transfers, and compares every result transfer.
// Depends on bcnp_pkg and the bcnp_in_if, bcnp_out_if and bcnp_cfg_if interfaces.
module bcnp_corner_checker (
  input  logic clk,
  input  logic rst_n,
  bcnp_in_if   in_ch,
  bcnp_out_if  out_ch,
  bcnp_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import bcnp_pkg::*;

  coord_t box_lo [AXES];
  coord_t box_hi [AXES];
  dist_t  cutoff;

  dist_t  best_dist [CORNERS];
  vid_t   best_id   [CORNERS];
  logic   have_best [CORNERS];

  out_item_t expected_corners [$];

  function automatic dist_t axis_sq(coord_t p, coord_t b);
    longint diff;
    longint mag;
    diff = longint'(p) - longint'(b);
    mag  = (diff < 0) ? -diff : diff;
    if (mag >= (longint'(1) << 21)) return DIST_MAX;
    return dist_t'(mag * mag);
  endfunction

  function automatic dist_t corner_sq_distance(in_item_t v, int c);
    coord_t          pos [AXES];
    logic [DIST_W:0] sum;
    sum    = '0;
    pos[0] = v.x_coord;
    pos[1] = v.y_coord;
    pos[2] = v.z_coord;
    for (int a = 0; a < AXES; a++) begin
      sum = sum + axis_sq(pos[a], c[a] ? box_hi[a] : box_lo[a]);
      if (sum > DIST_MAX) sum = DIST_MAX;
    end
    return dist_t'(sum);
  endfunction

  task automatic clear_bests();
    for (int c = 0; c < CORNERS; c++) begin
      best_dist[c] = '0;
      best_id[c]   = '0;
      have_best[c] = 1'b0;
    end
  endtask

  task automatic apply_cfg(cfg_wr_t w);
    case (w.index)
      CFG_BOX_MIN_X: box_lo[0] = coord_t'(w.value[COORD_W-1:0]);
      CFG_BOX_MIN_Y: box_lo[1] = coord_t'(w.value[COORD_W-1:0]);
      CFG_BOX_MIN_Z: box_lo[2] = coord_t'(w.value[COORD_W-1:0]);
      CFG_BOX_MAX_X: box_hi[0] = coord_t'(w.value[COORD_W-1:0]);
      CFG_BOX_MAX_Y: box_hi[1] = coord_t'(w.value[COORD_W-1:0]);
      CFG_BOX_MAX_Z: box_hi[2] = coord_t'(w.value[COORD_W-1:0]);
      CFG_CUTOFF_SQ: cutoff    = w.value;
      default: ;
    endcase
  endtask

  // Strictly closer than both the cutoff and the stored best; earliest wins ties.
  task automatic fold_vertex(in_item_t v);
    dist_t     d;
    out_item_t r;
    for (int c = 0; c < CORNERS; c++) begin
      d = corner_sq_distance(v, c);
      if (d < cutoff && (!have_best[c] || d < best_dist[c])) begin
        best_dist[c] = d;
        best_id[c]   = v.vertex_id;
        have_best[c] = 1'b1;
      end
    end
    if (v.final_vertex) begin
      for (int k = 0; k < CORNERS; k++) begin
        r.corner_index = cidx_t'(k);
        r.nearest_id   = have_best[k] ? best_id[k] : '0;
        r.found        = have_best[k];
        r.last_result  = (k == CORNERS - 1);
        expected_corners.push_back(r);
      end
      clear_bests();
    end
  endtask

  task automatic report_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_corners.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, actual corner %0d id %0d found %0d last %0d",
               $time, got.corner_index, got.nearest_id, got.found, got.last_result);
    end else begin
      want = expected_corners.pop_front();
      report_field("corner_index", ID_W'(want.corner_index), ID_W'(got.corner_index));
      report_field("nearest_id",   want.nearest_id,          got.nearest_id);
      report_field("found",        ID_W'(want.found),        ID_W'(got.found));
      report_field("last_result",  ID_W'(want.last_result),  ID_W'(got.last_result));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        box_lo[a] = '0;
        box_hi[a] = '0;
      end
      cutoff = CUTOFF_RESET;
      clear_bests();
      expected_corners.delete();
      fail_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_cfg(cfg_ch.data);
      if (in_ch.valid && in_ch.ready) fold_vertex(in_ch.data);
      if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
    end
    pending <= expected_corners.size();
  end

endmodule

/* sim/tb_box_corner_nearest_point_top.sv */
// tb_box_corner_nearest_point_top: drives vertex sets and box settings into the
// box corner nearest point block and gives the verdict; checking is done by
// bcnp_corner_checker. Depends on bcnp_pkg, the channel interfaces and the RTL.
module tb_box_corner_nearest_point_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcnp_pkg::*;

  localparam int     CLK_HALF_NS   = 6;
  localparam int     RESET_CYCLES  = 6;
  localparam int     IDLE_PCT      = 29;   // percent of cycles each side idles
  localparam int     HOLD_CYCLES   = 120;  // long receiver hold-off
  localparam int     SETTLE_CYCLES = 8;    // pipeline is 3 deep; margin on top
  localparam int     PHASES        = 6;
  localparam int     PHASE_ITEMS   = 75;
  localparam longint LIMIT_NS      = 3_000_000;

  // Index past the last register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  // Directed box: +-100 x, +-50 y, +-25 z in Q11.8. From its center every
  // corner lies at 25600^2 + 12800^2 + 6400^2.
  localparam int    DIR_X    = 25600;
  localparam int    DIR_Y    = 12800;
  localparam int    DIR_Z    = 6400;
  localparam dist_t D_CENTER = 42'd860160000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  bcnp_in_if  in_ch ();
  bcnp_out_if out_ch ();
  bcnp_cfg_if cfg_ch ();

  box_corner_nearest_point_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bcnp_corner_checker u_corner_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF_NS;
    clk = 1'b1;
    #CLK_HALF_NS;
  end

  // Current box, kept here only to aim vertices at the corners.
  coord_t cur_lo [AXES];
  coord_t cur_hi [AXES];
  dist_t  cur_cutoff;

  // Last vertex position sent; reused to force exact distance ties.
  coord_t last_x = '0;
  coord_t last_y = '0;
  coord_t last_z = '0;

  bit   source_steady = 1'b0;  // sender offers every cycle
  logic sink_steady   = 1'b0;  // receiver always ready
  logic hold_toggle   = 1'b0;  // flip to request one long receiver hold-off
  logic hold_seen;
  int   hold_left;

  // Receiver: random ready, a no-idle stretch on request, and a long
  // hold-off counted here so the sender keeps offering meanwhile.
  initial begin
    out_ch.ready <= 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= sink_steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #LIMIT_NS;
    $display("TEST FAILED");
    $finish;
  end

  function automatic coord_t corner_axis(int c, int a);
    return c[a] ? cur_hi[a] : cur_lo[a];
  endfunction

  // Random offset around a bound, clamped to the coordinate range.
  function automatic coord_t jitter(coord_t base, int unsigned spread);
    longint v;
    v = longint'(base) + longint'($urandom_range(2 * spread)) - longint'(spread);
    if (v < longint'(COORD_MIN)) v = longint'(COORD_MIN);
    if (v > longint'(COORD_MAX)) v = longint'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic dist_t pick_cutoff();
    case ($urandom_range(4))
      0:       return CUTOFF_RESET;
      1:       return DIST_MAX;
      2:       return dist_t'({$urandom(), $urandom()});
      3:       return dist_t'($urandom_range(0, 400));  // only near-exact hits pass
      default: return dist_t'($urandom());
    endcase
  endfunction

  // One vertex transfer, with random gaps ahead of it unless steady.
  task automatic send_vertex(vid_t id, coord_t x, coord_t y, coord_t z, logic fin);
    if (!source_steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{vertex_id: id, x_coord: x, y_coord: y, z_coord: z, final_vertex: fin};
    do @(posedge clk); while (!in_ch.ready);
    last_x = x;
    last_y = y;
    last_z = z;
  endtask

  // Leaves cfg valid high; the caller lowers it after its last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, dist_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: value};
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic program_box();
    write_reg(CFG_BOX_MIN_X, dist_t'(cur_lo[0]));
    write_reg(CFG_BOX_MIN_Y, dist_t'(cur_lo[1]));
    write_reg(CFG_BOX_MIN_Z, dist_t'(cur_lo[2]));
    write_reg(CFG_BOX_MAX_X, dist_t'(cur_hi[0]));
    write_reg(CFG_BOX_MAX_Y, dist_t'(cur_hi[1]));
    write_reg(CFG_BOX_MAX_Z, dist_t'(cur_hi[2]));
    write_reg(CFG_CUTOFF_SQ, cur_cutoff);
    write_reg(CFG_SPARE, dist_t'({$urandom(), $urandom()}));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_cutoff(dist_t value);
    cur_cutoff = value;
    write_reg(CFG_CUTOFF_SQ, value);
    cfg_ch.valid <= 1'b0;
  endtask

  // Sender pauses until every predicted result has been seen.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Non-final vertices leave no result behind, so give the pipeline time to
  // empty before touching the registers.
  task automatic quiesce();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A set of random vertices; close marks the last one final.
  task automatic send_random_set(int unsigned len, bit close);
    int unsigned r;
    int          c;
    int unsigned spread;
    vid_t        id;
    coord_t      x, y, z;
    for (int unsigned i = 0; i < len; i++) begin
      r  = $urandom_range(99);
      id = vid_t'($urandom());
      if (r < 10) begin
        // same spot as the previous vertex: earlier one must keep the corner
        x = last_x;
        y = last_y;
        z = last_z;
      end else if (r < 40) begin
        x = coord_t'($urandom());
        y = coord_t'($urandom());
        z = coord_t'($urandom());
      end else begin
        c      = int'($urandom_range(CORNERS - 1));
        spread = $urandom_range(1) ? 8 : 4096;
        x = jitter(corner_axis(c, 0), spread);
        y = jitter(corner_axis(c, 1), spread);
        z = jitter(corner_axis(c, 2), spread);
      end
      send_vertex(id, x, y, z, close && (i == len - 1));
    end
  endtask

  // Box and cutoff per random phase: small, full range, inverted,
  // fully random and degenerate boxes.
  task automatic configure_phase(int p);
    int lo_v;
    int span;
    for (int a = 0; a < AXES; a++) begin
      lo_v = int'($urandom_range(0, 2 * DIR_X)) - DIR_X;
      span = int'($urandom_range(0, DIR_X));
      case (p)
        1: begin
          cur_lo[a] = COORD_MIN;
          cur_hi[a] = COORD_MAX;
        end
        2: begin
          cur_hi[a] = coord_t'(lo_v);
          cur_lo[a] = coord_t'(lo_v + span + 1);
        end
        3: begin
          cur_lo[a] = coord_t'($urandom());
          cur_hi[a] = coord_t'($urandom());
        end
        4: begin
          cur_lo[a] = coord_t'(lo_v);
          cur_hi[a] = coord_t'(lo_v);
        end
        default: begin
          cur_lo[a] = coord_t'(lo_v);
          cur_hi[a] = coord_t'(lo_v + span);
        end
      endcase
    end
    if (p == 1)      cur_cutoff = DIST_MAX;
    else if (p == 5) cur_cutoff = CUTOFF_RESET;
    else             cur_cutoff = pick_cutoff();
    program_box();
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned len;
    bit          paused;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    cur_lo[0] = coord_t'(-DIR_X);
    cur_lo[1] = coord_t'(-DIR_Y);
    cur_lo[2] = coord_t'(-DIR_Z);
    cur_hi[0] = coord_t'(DIR_X);
    cur_hi[1] = coord_t'(DIR_Y);
    cur_hi[2] = coord_t'(DIR_Z);
    cur_cutoff = CUTOFF_RESET;
    program_box();

    // Center first, then each corner exactly; a later vertex on corner 0 ties
    // at zero and must lose. The final vertex sits far outside the cutoff.
    send_vertex(16'd0, '0, '0, '0, 1'b0);
    for (int c = 0; c < CORNERS; c++)
      send_vertex(vid_t'(c + 1), corner_axis(c, 0), corner_axis(c, 1), corner_axis(c, 2), 1'b0);
    send_vertex(16'hFFFF, corner_axis(0, 0), corner_axis(0, 1), corner_axis(0, 2), 1'b0);
    send_vertex(16'd9, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);

    // Nothing within the cutoff: every corner reports not found.
    send_vertex(16'd10, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);

    // Cutoff lowered to zero mid-set: the stored center vertex stays.
    send_vertex(16'd11, '0, '0, '0, 1'b0);
    quiesce();
    set_cutoff('0);
    send_vertex(16'd12, corner_axis(3, 0), corner_axis(3, 1), corner_axis(3, 2), 1'b1);

    // Distance equal to the cutoff is rejected, one below it is taken.
    quiesce();
    set_cutoff(D_CENTER);
    send_vertex(16'd13, '0, '0, '0, 1'b1);
    quiesce();
    set_cutoff(D_CENTER + 1);
    send_vertex(16'd14, '0, '0, '0, 1'b1);

    // Inverted box at the coordinate extremes with the largest cutoff.
    quiesce();
    for (int a = 0; a < AXES; a++) begin
      cur_lo[a] = COORD_MAX;
      cur_hi[a] = COORD_MIN;
    end
    cur_cutoff = DIST_MAX;
    program_box();
    send_vertex(16'd15, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(16'd16, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(16'd17, '0, '0, '0, 1'b1);

    // ---- random part ----
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      configure_phase(p);
      // phase 1 runs with no idling on either side
      source_steady = (p == 1);
      sink_steady <= (p == 1);
      // phase 2 starts under a long receiver hold-off so the block backs up
      if (p == 2) hold_toggle <= ~hold_toggle;
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 10);
        send_random_set(len, 1'b1);
        sent += len;
        if (p == 3 && !paused && sent >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
      // sometimes leave a set open across the next register update
      if ($urandom_range(2) == 0) send_random_set($urandom_range(1, 3), 1'b0);
    end
    source_steady = 1'b0;
    sink_steady <= 1'b0;

    // Close any open set so its bests are reported too.
    send_random_set(1, 1'b1);
    quiesce();

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
